>>> rtl/pcmf_pkg.sv
// ----------------------------------------------------------------------------
// pcmf_pkg
// Shared constants, types and helper functions of the PCM to float converter.
// ----------------------------------------------------------------------------
package pcmf_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned FloatW = 32;
    localparam int unsigned FmtW   = 3;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgDataW = 32;

    localparam logic [FmtW-1:0] FMT_U8  = 3'd0;
    localparam logic [FmtW-1:0] FMT_S8  = 3'd1;
    localparam logic [FmtW-1:0] FMT_S16 = 3'd2;
    localparam logic [FmtW-1:0] FMT_S24 = 3'd3;
    localparam logic [FmtW-1:0] FMT_S32 = 3'd4;

    localparam logic [CfgIdxW-1:0] REG_FORMAT = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_MONO   = 1'd1;

    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
        logic [7:0]  bias_exp;
    } t_sample;

    function automatic logic [FmtW-1:0] active_fmt(input logic [FmtW-1:0] f);
        active_fmt = (f > FMT_S32) ? FMT_S16 : f;
    endfunction

    function automatic logic [1:0] last_pos(input logic [FmtW-1:0] f);
        unique case (f)
            FMT_U8, FMT_S8: last_pos = 2'd0;
            FMT_S24:        last_pos = 2'd2;
            FMT_S32:        last_pos = 2'd3;
            default:        last_pos = 2'd1;
        endcase
    endfunction

endpackage

>>> rtl/pcmf_if.sv
// ----------------------------------------------------------------------------
// pcmf_if
// Valid/ready channels: byte input, float output and register writes.
// ----------------------------------------------------------------------------
interface pcmf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface pcmf_float_if;
    logic        valid;
    logic        ready;
    logic [31:0] float_bits;
    logic        last_copy;
    modport source (output valid, output float_bits, output last_copy, input ready);
    modport sink   (input valid, input float_bits, input last_copy, output ready);
endinterface

interface pcmf_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/pcm_bytes_to_float_converter_top.sv
// ----------------------------------------------------------------------------
// pcm_bytes_to_float_converter_top
// PCM byte stream to IEEE-754 single precision converter.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle unless the output stalls. Bytes are gathered
// into a sample in the input stage; the completed sample is registered and
// converted to a float in the next stage, whose output register holds the
// result. The last byte of a sample passes the sample register and then the
// output register before its result appears. In mono mode a sample yields two
// results and can hold the input back while the second copy is sent.
module pcm_bytes_to_float_converter_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcmf_byte_if.sink     in_ch,
    pcmf_float_if.source  out_ch,
    pcmf_cfg_if.sink      cfg_ch
);
    logic [pcmf_pkg::FmtW-1:0] r_fmt;
    logic                      r_mono;
    logic                      take, done, clr;
    pcmf_pkg::t_sample         smp;
    pcmf_pkg::t_sample         r_smp;
    logic                      r_sv;
    logic                      r_smono;
    logic [31:0]               bits;
    logic                      r_ov;
    logic [31:0]               r_obits;
    logic                      r_olast;
    logic                      r_dup;
    logic                      out_free, mid_free;

    assign cfg_ch.ready = 1'b1;
    assign clr = cfg_ch.valid && cfg_ch.index == pcmf_pkg::REG_FORMAT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= pcmf_pkg::FMT_S16;
            r_mono <= 1'b0;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                pcmf_pkg::REG_FORMAT: r_fmt  <= cfg_ch.data[2:0];
                default:              r_mono <= cfg_ch.data[0];
            endcase
        end
    end

    // output stage free if empty or being taken and no pending duplicate
    assign out_free = !r_ov || (out_ch.ready && !r_dup);
    assign mid_free = !r_sv || out_free;
    assign in_ch.ready = mid_free;
    assign take = in_ch.valid && in_ch.ready;

    pcmf_gather u_gather (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (in_ch.data_byte),
        .i_clear  (clr),
        .i_fmt    (r_fmt),
        .o_done   (done),
        .o_sample (smp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (mid_free) begin
            r_sv <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mid_free && done) begin
            r_smp   <= smp;
            r_smono <= r_mono;
        end
    end

    pcmf_pack u_pack (
        .i_sample (r_smp),
        .o_bits   (bits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_dup <= 1'b0;
        end else if (r_ov && r_dup && out_ch.ready) begin
            r_dup <= 1'b0;
        end else if (out_free) begin
            r_ov  <= r_sv;
            r_dup <= r_sv && r_smono;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ov && r_dup && out_ch.ready) begin
            r_olast <= 1'b1;
        end else if (out_free && r_sv) begin
            r_obits <= bits;
            r_olast <= !r_smono;
        end
    end

    assign out_ch.valid      = r_ov;
    assign out_ch.float_bits = r_obits;
    assign out_ch.last_copy  = r_olast;

    a_dup_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dup && r_ov |-> !r_olast) else $error("duplicate pending on last copy");
    a_dup_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_dup && out_ch.ready |=> r_ov && r_olast && $stable(r_obits))
        else $error("second copy lost");
    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv && r_ov && !out_ch.ready |-> !in_ch.ready) else $error("input not stalled");
endmodule

>>> rtl/pcmf_gather.sv
// ----------------------------------------------------------------------------
// pcmf_gather
// Collects bytes into a sample and decodes it to sign, magnitude, exponent.
// ----------------------------------------------------------------------------
module pcmf_gather (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic [7:0]                  i_byte,
    input  logic                        i_clear,
    input  logic [pcmf_pkg::FmtW-1:0]   i_fmt,
    output logic                        o_done,
    output pcmf_pkg::t_sample           o_sample
);
    logic [23:0] r_acc;
    logic [1:0]  r_pos;
    logic [31:0] raw;
    logic        last;
    logic [pcmf_pkg::FmtW-1:0] fmt;
    logic signed [32:0] val;

    assign fmt    = pcmf_pkg::active_fmt(i_fmt);
    assign last   = (r_pos == pcmf_pkg::last_pos(fmt));
    assign o_done = i_take && last;

    always_comb begin
        raw = {8'd0, r_acc};
        unique case (r_pos)
            2'd0: raw[7:0]   = i_byte;
            2'd1: raw[15:8]  = i_byte;
            2'd2: raw[23:16] = i_byte;
            default: raw[31:24] = i_byte;
        endcase
        unique case (fmt)
            pcmf_pkg::FMT_U8: begin
                val = $signed({25'd0, raw[7:0]}) - 33'sd128;
                o_sample.bias_exp = 8'd135;
            end
            pcmf_pkg::FMT_S8: begin
                val = {{25{raw[7]}}, raw[7:0]};
                o_sample.bias_exp = 8'd135;
            end
            pcmf_pkg::FMT_S24: begin
                val = {{9{raw[23]}}, raw[23:0]};
                o_sample.bias_exp = 8'd119;
            end
            pcmf_pkg::FMT_S32: begin
                val = {raw[31], raw};
                o_sample.bias_exp = 8'd111;
            end
            default: begin
                val = {{17{raw[15]}}, raw[15:0]};
                o_sample.bias_exp = 8'd127;
            end
        endcase
        o_sample.neg = val[32];
        o_sample.mag = val[32] ? 32'(-val) : val[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_acc <= '0;
            r_pos <= '0;
        end else if (i_take) begin
            if (last) begin
                r_acc <= '0;
                r_pos <= '0;
            end else begin
                r_acc <= raw[23:0];
                r_pos <= r_pos + 2'd1;
            end
        end
    end
endmodule

>>> rtl/pcmf_pack.sv
// ----------------------------------------------------------------------------
// pcmf_pack
// Normalizes a registered magnitude and rounds it to single precision bits.
// ----------------------------------------------------------------------------
module pcmf_pack (
    input  pcmf_pkg::t_sample  i_sample,
    output logic [31:0]        o_bits
);
    logic [4:0]  top;
    logic [31:0] norm;
    logic [23:0] frac;
    logic        grd, stk;
    logic [24:0] rnd;
    logic [7:0]  expo;

    always_comb begin
        top = '0;
        for (int i = 0; i < 32; i++) begin
            if (i_sample.mag[i]) top = 5'(i);
        end
        norm = i_sample.mag << (5'd31 - top);
        frac = norm[31:8];
        grd  = norm[7];
        stk  = |norm[6:0];
        rnd  = {1'b0, frac} + 25'(grd && (stk || frac[0]));
        expo = i_sample.bias_exp + 8'(top) + 8'(rnd[24]);
        if (i_sample.mag == '0) begin
            o_bits = '0;
        end else begin
            o_bits = {i_sample.neg, expo,
                      rnd[24] ? rnd[23:1] : rnd[22:0]};
        end
    end
endmodule

>>> verif/pcmf_checker.sv
// ----------------------------------------------------------------------------
// pcmf_checker
// Watches the byte, float and register channels of the PCM to float
// converter, predicts every float item from the accepted bytes and the
// register settings, and compares each output item field by field.
// ----------------------------------------------------------------------------
module pcmf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_bits,
    input  logic        i_out_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_pending,
    output int          o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] bits;
        logic        last;
    } t_float_item;

    t_float_item                float_q[$];
    logic [pcmf_pkg::FmtW-1:0]  fmt_reg;
    logic                       mono_reg;
    logic [23:0]                partial;
    logic [1:0]                 pos;
    int                         errors;

    assign o_pending = float_q.size();
    assign o_errors  = errors;

    function automatic logic [31:0] to_single(input logic neg, input logic [31:0] mag,
                                              input int scale);
        int          top;
        int          sh;
        logic [31:0] frac;
        logic [31:0] rem;
        logic [31:0] half;
        top = 31;
        if (mag == 0) return 32'h0;
        while (mag[top] == 1'b0) top--;
        if (top <= 23) begin
            frac = mag << (23 - top);
        end else begin
            sh   = top - 23;
            rem  = mag & ((32'h1 << sh) - 1);
            half = 32'h1 << (sh - 1);
            frac = mag >> sh;
            if (rem > half || (rem == half && frac[0])) frac++;
            if (frac == 32'h0100_0000) begin
                frac = frac >> 1;
                top++;
            end
        end
        return {neg, 8'(top + scale + 127), frac[22:0]};
    endfunction

    function automatic logic [31:0] convert_sample(input logic [pcmf_pkg::FmtW-1:0] f,
                                                   input logic [31:0] raw);
        longint val;
        int     scale;
        case (f)
            pcmf_pkg::FMT_U8: begin
                val = longint'(raw[7:0]) - 128;
                scale = 8;
            end
            pcmf_pkg::FMT_S8: begin
                val = longint'($signed(raw[7:0]));
                scale = 8;
            end
            pcmf_pkg::FMT_S24: begin
                val = longint'($signed(raw[23:0]));
                scale = -8;
            end
            pcmf_pkg::FMT_S32: begin
                val = longint'($signed(raw));
                scale = -16;
            end
            default: begin
                val = longint'($signed(raw[15:0]));
                scale = 0;
            end
        endcase
        return to_single(val < 0, 32'(val < 0 ? -val : val), scale);
    endfunction

    always @(posedge i_clk) begin
        logic [pcmf_pkg::FmtW-1:0] f;
        logic [1:0]                need;
        logic [31:0]               raw;
        logic [31:0]               bits;
        logic [23:0]               n_partial;
        logic [1:0]                n_pos;
        int                        n_err;
        t_float_item               got;
        t_float_item               exp_item;
        if (!i_rst_n) begin
            fmt_reg  <= pcmf_pkg::FMT_S16;
            mono_reg <= 1'b0;
            partial  <= '0;
            pos      <= '0;
            errors   <= 0;
            float_q.delete();
        end else begin
            n_partial = partial;
            n_pos     = pos;
            n_err     = 0;
            if (i_in_valid && i_in_ready) begin
                f = (fmt_reg > pcmf_pkg::FMT_S32) ? pcmf_pkg::FMT_S16 : fmt_reg;
                case (f)
                    pcmf_pkg::FMT_U8, pcmf_pkg::FMT_S8: need = 2'd0;
                    pcmf_pkg::FMT_S24:                  need = 2'd2;
                    pcmf_pkg::FMT_S32:                  need = 2'd3;
                    default:                            need = 2'd1;
                endcase
                if (pos < need) begin
                    n_partial = partial | (24'(i_in_byte) << (8 * pos));
                    n_pos     = pos + 2'd1;
                end else begin
                    raw  = {8'h0, partial} | (32'(i_in_byte) << (8 * pos));
                    bits = convert_sample(f, raw);
                    if (mono_reg) float_q.push_back('{bits, 1'b0});
                    float_q.push_back('{bits, 1'b1});
                    n_partial = '0;
                    n_pos     = '0;
                end
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_out_bits, i_out_last};
                if (float_q.size() == 0) begin
                    $error("unexpected item: float_bits %h last_copy %b", got.bits, got.last);
                    n_err++;
                end else begin
                    exp_item = float_q.pop_front();
                    if (got.bits !== exp_item.bits) begin
                        $error("float_bits expected %h actual %h", exp_item.bits, got.bits);
                        n_err++;
                    end
                    if (got.last !== exp_item.last) begin
                        $error("last_copy expected %b actual %b", exp_item.last, got.last);
                        n_err++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == pcmf_pkg::REG_FORMAT) begin
                    fmt_reg   <= i_cfg_data[pcmf_pkg::FmtW-1:0];
                    n_partial = '0;
                    n_pos     = '0;
                end else if (i_cfg_index == pcmf_pkg::REG_MONO) begin
                    mono_reg <= i_cfg_data[0];
                end
            end
            partial <= n_partial;
            pos     <= n_pos;
            errors  <= errors + n_err;
        end
    end
endmodule

>>> verif/pcm_bytes_to_float_converter_top_tb.sv
// ----------------------------------------------------------------------------
// pcm_bytes_to_float_converter_top_tb
// Drives byte streams through every sample format with and without mono
// duplication, directed extremes first, then random bytes with random
// gaps and output stalls; the checker predicts and compares the floats.
// ----------------------------------------------------------------------------
module pcm_bytes_to_float_converter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchLimit = 20000;

    logic i_clk;
    logic i_rst_n;
    int   pending;
    int   errors;
    int   idle_cycles;
    bit   hold_out;
    bit   done;

    pcmf_byte_if  in_ch();
    pcmf_float_if out_ch();
    pcmf_cfg_if   cfg_ch();

    pcm_bytes_to_float_converter_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .cfg_ch  (cfg_ch.sink)
    );

    pcmf_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_in_byte   (in_ch.data_byte),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_bits  (out_ch.float_bits),
        .i_out_last  (out_ch.last_copy),
        .i_cfg_valid (cfg_ch.valid),
        .i_cfg_ready (cfg_ch.ready),
        .i_cfg_index (cfg_ch.index),
        .i_cfg_data  (cfg_ch.data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    // valid stays high after an item; drain drops it
    task automatic send_byte(input logic [7:0] b, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g != 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++) send_byte(v[8*k +: 8], 1'b0);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n || hold_out) begin
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            out_ch.ready <= ($urandom_range(0, 9) == 0) ? 1'b1 : 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchLimit) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int nb;
        int fmts[5] = '{1, 1, 2, 3, 4};
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        hold_out        = 1'b0;
        done            = 1'b0;
        i_rst_n         = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes of every format at reset setting first
        send_sample(32'h0000_8000, 2);
        send_sample(32'h0000_7fff, 2);
        send_sample(32'h0000_0000, 2);
        for (int f = 0; f < 5; f++) begin
            write_reg(pcmf_pkg::REG_FORMAT, 32'(f));
            send_sample(32'h0000_0000, fmts[f]);
            send_sample(32'hffff_ffff, fmts[f]);
            send_sample(32'h8080_8080, fmts[f]);
            send_sample(32'h7f7f_7f7f, fmts[f]);
        end
        write_reg(pcmf_pkg::REG_FORMAT, 32'd7);
        send_sample(32'h0000_0001, 2);
        write_reg(pcmf_pkg::REG_MONO, 32'd1);
        send_byte(8'h12, 1'b0);
        write_reg(pcmf_pkg::REG_FORMAT, 32'(pcmf_pkg::FMT_S24));
        send_sample(32'h0080_0001, 3);
        send_byte(8'h55, 1'b0);
        write_reg(pcmf_pkg::REG_MONO, 32'd0);
        send_sample(32'h0000_ff00, 2);

        // random: phases of format and mono, including extremes
        for (int p = 0; p < 16; p++) begin
            write_reg(pcmf_pkg::REG_FORMAT,
                      (p < 14) ? 32'(p % 5) : 32'($urandom_range(5, 7)));
            write_reg(pcmf_pkg::REG_MONO, 32'((p / 5) % 2));
            if (p == 3) hold_out <= 1'b1;
            fork
                begin
                    if (p == 3) begin
                        repeat (300) @(negedge i_clk);
                        hold_out <= 1'b0;
                    end
                end
                begin
                    nb = $urandom_range(100, 150);
                    for (int i = 0; i < nb; i++) begin
                        send_byte(8'($urandom), (p != 3) && ($urandom_range(0, 7) != 0));
                    end
                end
            join
        end
        drain();
        done = 1'b1;
        repeat (10) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
